FILE: rtl/orct_pkg.sv
// ----------------------------------------------------------------------------
// Object reference count table: shared package
// Operation and status codes, command and result types, table entry layout.
// ----------------------------------------------------------------------------
package orct_pkg;

    localparam int ID_W            = 64;
    localparam int COUNT_W         = 31;
    localparam int ENTRIES_DEFAULT = 64;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_INC    = 3'd2,
        OP_DEC    = 3'd3,
        OP_QUERY  = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_PRESENT    = 3'd1,
        ST_ABSENT     = 3'd2,
        ST_NEGATIVE   = 3'd3,
        ST_REFERENCED = 3'd4,
        ST_FULL       = 3'd5,
        ST_OVERFLOW   = 3'd6
    } status_t;

    // Work classes assigned by the front end.
    typedef enum logic [2:0] {
        K_INSERT,
        K_REMOVE,
        K_INC,
        K_DEC,
        K_QUERY,
        K_PEEK,
        K_CLEAR,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   id;
    } cmd_t;

    typedef struct packed {
        status_t              status;
        logic                 found;
        logic [COUNT_W-1:0]   count;
        logic                 in_use;
    } result_t;

    typedef struct packed {
        logic                 valid;
        logic [ID_W-1:0]      key;
        logic [COUNT_W-1:0]   count;
    } entry_t;

endpackage

FILE: rtl/object_reference_count_table_core.sv
// ----------------------------------------------------------------------------
// Object reference count table
// Table of object ids with reference counts, one result item per input item.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready, operation, object_id) takes one item
// per handshake, and the output channel (out_valid, out_ready, status, found,
// ref_count, in_use) returns exactly one result item for it, in order.
// The table lives in a memory that is scanned one entry per cycle; the scan
// stops at the slot that holds the id, while a miss or an insert of a new id
// scans every entry. Clear all rewrites every entry. One item is worked on at
// a time.
// The front end and a two-entry queue keep accepting up to three items while
// the engine is busy or while a finished result waits in the output register.
// After reset the engine clears the whole memory, and in_ready stays low until
// it is done. When out_ready is low the result holds and the engine waits;
// new items still enter until the queue is full.
// ----------------------------------------------------------------------------
module object_reference_count_table_core #(
    parameter int ENTRIES = orct_pkg::ENTRIES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     operation,
    input  logic [orct_pkg::ID_W-1:0]      object_id,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     status,
    output logic                           found,
    output logic [orct_pkg::COUNT_W-1:0]   ref_count,
    output logic                           in_use
);

    logic              front_valid;
    logic              front_ready;
    orct_pkg::cmd_t    front_cmd;
    logic              queue_valid;
    logic              queue_ready;
    orct_pkg::cmd_t    queue_cmd;
    logic              init_busy;
    orct_pkg::result_t result;

    orct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (!init_busy),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .object_id (object_id),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    orct_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_cmd)
    );

    orct_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .init_busy (init_busy),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (result)
    );

    assign status    = result.status;
    assign found     = result.found;
    assign ref_count = result.count;
    assign in_use    = result.in_use;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (in_use == (ref_count != '0)))
        else $error("in_use disagrees with ref_count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == orct_pkg::ST_ABSENT || status == orct_pkg::ST_FULL))
        |-> (!found && ref_count == '0))
        else $error("absent or full result reports an entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == orct_pkg::ST_PRESENT || status == orct_pkg::ST_REFERENCED
            || status == orct_pkg::ST_NEGATIVE || status == orct_pkg::ST_OVERFLOW))
        |-> found)
        else $error("failed operation on a present id without found");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == orct_pkg::ST_OVERFLOW) |-> (ref_count == orct_pkg::COUNT_MAX))
        else $error("overflow reported below the maximum count");
`endif

endmodule

FILE: rtl/orct_front.sv
// ----------------------------------------------------------------------------
// Object reference count table: front end
// Accepts items, decodes the operation into a work class and holds one
// classified command until the queue takes it.
// ----------------------------------------------------------------------------
module orct_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        enable,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  operation,
    input  logic [orct_pkg::ID_W-1:0]   object_id,
    output logic                        cmd_valid,
    input  logic                        cmd_ready,
    output orct_pkg::cmd_t              cmd
);

    logic           cmd_valid_reg;
    logic           cmd_valid_next;
    orct_pkg::cmd_t cmd_reg;
    orct_pkg::cmd_t cmd_next;
    orct_pkg::cmd_t decoded;
    logic           null_id;

    assign null_id = (object_id == '0);

    always_comb
    begin
        decoded.id = object_id;
        unique case (operation)
            orct_pkg::OP_INSERT: decoded.kind = orct_pkg::K_INSERT;
            orct_pkg::OP_REMOVE: decoded.kind = orct_pkg::K_REMOVE;
            orct_pkg::OP_INC:    decoded.kind = null_id ? orct_pkg::K_PEEK : orct_pkg::K_INC;
            orct_pkg::OP_DEC:    decoded.kind = null_id ? orct_pkg::K_PEEK : orct_pkg::K_DEC;
            orct_pkg::OP_QUERY:  decoded.kind = orct_pkg::K_QUERY;
            orct_pkg::OP_CLEAR:  decoded.kind = orct_pkg::K_CLEAR;
            default:             decoded.kind = orct_pkg::K_NOP;
        endcase
    end

    assign in_ready  = enable && (!cmd_valid_reg || cmd_ready);
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg && !cmd_ready;
        cmd_next       = cmd_reg;
        if (in_valid && in_ready)
        begin
            cmd_valid_next = 1'b1;
            cmd_next       = decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            cmd_reg       <= '0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            cmd_reg       <= cmd_next;
        end
    end

endmodule

FILE: rtl/orct_queue.sv
// ----------------------------------------------------------------------------
// Object reference count table: command queue
// Short first-in first-out buffer between the front end and the table engine.
// ----------------------------------------------------------------------------
module orct_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  orct_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output orct_pkg::cmd_t pop_data
);

    localparam int AW = orct_pkg::QUEUE_AW;

    orct_pkg::cmd_t slots [orct_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW-1:0]  rd_ptr_next;
    logic [AW:0]    fill_reg;
    logic [AW:0]    fill_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (fill_reg != (AW+1)'(orct_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        fill_next   = fill_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

FILE: rtl/orct_back.sv
// ----------------------------------------------------------------------------
// Object reference count table: table engine
// Holds the table in a single-port-write memory, scans it one entry per
// cycle to find the id and the lowest free slot, applies the operation and
// drives the output register.
// ----------------------------------------------------------------------------
module orct_back #(
    parameter int ENTRIES = orct_pkg::ENTRIES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  orct_pkg::cmd_t    cmd,
    output logic              init_busy,
    output logic              res_valid,
    input  logic              res_ready,
    output orct_pkg::result_t res
);

    localparam int AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_DONE
    } state_t;

    orct_pkg::entry_t mem [ENTRIES];
    orct_pkg::entry_t rd_data_reg;

    state_t                         state_reg, state_next;
    orct_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [AW-1:0]                  scan_addr_reg, scan_addr_next;
    logic                           issuing_reg, issuing_next;
    logic                           chk_valid_reg, chk_valid_next;
    logic [AW-1:0]                  chk_addr_reg, chk_addr_next;
    logic                           hit_reg, hit_next;
    logic [AW-1:0]                  hit_slot_reg, hit_slot_next;
    logic [orct_pkg::COUNT_W-1:0]   hit_count_reg, hit_count_next;
    logic                           free_found_reg, free_found_next;
    logic [AW-1:0]                  free_slot_reg, free_slot_next;
    logic                           clear_op_reg, clear_op_next;
    orct_pkg::result_t              res_reg, res_next;
    logic                           out_valid_reg, out_valid_next;
    orct_pkg::result_t              out_res_reg, out_res_next;

    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    orct_pkg::entry_t               mem_wdata;
    orct_pkg::result_t              exec_res;
    logic                           key_match;

    assign key_match = rd_data_reg.valid && (rd_data_reg.key == cmd_reg.id);

    // Outcome and table write of the operation once the scan is complete, and the zeroing write while clearing.
    always_comb
    begin
        exec_res.status = orct_pkg::ST_OK;
        exec_res.found  = hit_reg;
        exec_res.count  = hit_reg ? hit_count_reg : '0;
        mem_we          = 1'b0;
        mem_waddr       = hit_slot_reg;
        mem_wdata.valid = 1'b1;
        mem_wdata.key   = cmd_reg.id;
        mem_wdata.count = hit_count_reg;
        unique case (cmd_reg.kind)
            orct_pkg::K_INSERT:
            begin
                if (hit_reg)
                begin
                    exec_res.status = orct_pkg::ST_PRESENT;
                end
                else if (!free_found_reg)
                begin
                    exec_res.status = orct_pkg::ST_FULL;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = free_slot_reg;
                    mem_wdata.count = '0;
                end
            end
            orct_pkg::K_REMOVE:
            begin
                if (hit_reg)
                begin
                    if (hit_count_reg != '0)
                    begin
                        exec_res.status = orct_pkg::ST_REFERENCED;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        mem_wdata.valid = 1'b0;
                    end
                end
            end
            orct_pkg::K_INC:
            begin
                if (!hit_reg)
                begin
                    exec_res.status = orct_pkg::ST_ABSENT;
                end
                else if (hit_count_reg == orct_pkg::COUNT_MAX)
                begin
                    exec_res.status = orct_pkg::ST_OVERFLOW;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_wdata.count = hit_count_reg + orct_pkg::COUNT_W'(1);
                    exec_res.count  = mem_wdata.count;
                end
            end
            orct_pkg::K_DEC:
            begin
                if (!hit_reg)
                begin
                    exec_res.status = orct_pkg::ST_ABSENT;
                end
                else if (hit_count_reg == '0)
                begin
                    exec_res.status = orct_pkg::ST_NEGATIVE;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_wdata.count = hit_count_reg - orct_pkg::COUNT_W'(1);
                    exec_res.count  = mem_wdata.count;
                end
            end
            orct_pkg::K_QUERY:
            begin
                if (!hit_reg)
                begin
                    exec_res.status = orct_pkg::ST_ABSENT;
                end
            end
            orct_pkg::K_PEEK:
            begin
                exec_res.status = orct_pkg::ST_OK;
            end
            default:
            begin
                exec_res.found = 1'b0;
                exec_res.count = '0;
            end
        endcase
        exec_res.in_use = (exec_res.count != '0);

        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = scan_addr_reg;
            mem_wdata = '0;
        end
        else if (state_reg != S_EXEC)
        begin
            mem_we = 1'b0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        scan_addr_next  = scan_addr_reg;
        issuing_next    = issuing_reg;
        chk_valid_next  = 1'b0;
        chk_addr_next   = scan_addr_reg;
        hit_next        = hit_reg;
        hit_slot_next   = hit_slot_reg;
        hit_count_next  = hit_count_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        clear_op_next   = clear_op_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_res_next    = out_res_reg;
        cmd_ready       = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                scan_addr_next = scan_addr_reg + AW'(1);
                if (scan_addr_reg == LAST)
                begin
                    clear_op_next = 1'b0;
                    res_next      = '0;
                    state_next    = clear_op_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next        = cmd;
                    scan_addr_next  = '0;
                    issuing_next    = 1'b1;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    unique case (cmd.kind)
                        orct_pkg::K_CLEAR:
                        begin
                            clear_op_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        orct_pkg::K_NOP:
                        begin
                            res_next   = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                chk_valid_next = issuing_reg;
                if (issuing_reg)
                begin
                    scan_addr_next = scan_addr_reg + AW'(1);
                    if (scan_addr_reg == LAST)
                    begin
                        issuing_next = 1'b0;
                    end
                end
                if (chk_valid_reg)
                begin
                    priority if (key_match)
                    begin
                        hit_next       = 1'b1;
                        hit_slot_next  = chk_addr_reg;
                        hit_count_next = rd_data_reg.count;
                        chk_valid_next = 1'b0;
                        state_next     = S_EXEC;
                    end
                    else
                    begin
                        if (!rd_data_reg.valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_slot_next  = chk_addr_reg;
                        end
                        if (chk_addr_reg == LAST)
                        begin
                            chk_valid_next = 1'b0;
                            state_next     = S_EXEC;
                        end
                    end
                end
            end
            S_EXEC:
            begin
                res_next   = exec_res;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[scan_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cmd_reg        <= '0;
            scan_addr_reg  <= '0;
            issuing_reg    <= 1'b0;
            chk_valid_reg  <= 1'b0;
            chk_addr_reg   <= '0;
            hit_reg        <= 1'b0;
            hit_slot_reg   <= '0;
            hit_count_reg  <= '0;
            free_found_reg <= 1'b0;
            free_slot_reg  <= '0;
            clear_op_reg   <= 1'b0;
            res_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_res_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            scan_addr_reg  <= scan_addr_next;
            issuing_reg    <= issuing_next;
            chk_valid_reg  <= chk_valid_next;
            chk_addr_reg   <= chk_addr_next;
            hit_reg        <= hit_next;
            hit_slot_reg   <= hit_slot_next;
            hit_count_reg  <= hit_count_next;
            free_found_reg <= free_found_next;
            free_slot_reg  <= free_slot_next;
            clear_op_reg   <= clear_op_next;
            res_reg        <= res_next;
            out_valid_reg  <= out_valid_next;
            out_res_reg    <= out_res_next;
        end
    end

    assign init_busy = (state_reg == S_CLEAR) && !clear_op_reg;
    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;

endmodule
